// ===== hw/rtl/bgpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bgpe_pkg
// Types, constants and the 5x7 font table shared by the glyph pixel emitter.
// ----------------------------------------------------------------------------
package bgpe_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int PIX_W   = 13;
  localparam int ADDR_W  = 26;
  localparam int COLOR_W = 32;
  localparam int CFG_W   = 14;

  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_BITS    = GLYPH_ROWS * GLYPH_COLS;
  localparam int GLYPH_COUNT   = 95;
  localparam int GLYPH_ADVANCE = 6;

  localparam logic [7:0]       GLYPH_FIRST = 8'd32;
  localparam logic [7:0]       GLYPH_LAST  = 8'd126;
  localparam logic [CFG_W-1:0] CLIP_MAX    = 14'd8192;

  // register indexes on the configuration port
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_FB_WIDTH = 2'd1;
  localparam logic [1:0] REG_FB_HEIGHT = 2'd2;
  localparam logic [1:0] REG_PITCH    = 2'd3;

  typedef struct packed {
    logic             enable;
    logic [CFG_W-1:0] fb_width;
    logic [CFG_W-1:0] fb_height;
    logic [CFG_W-1:0] row_pitch;
  } cfg_t;

  // one drawable character: pen position, clipped pixel mask, colour;
  // y0 keeps a sign bit so that a pen just above the top edge still
  // gives the right row address once the rows come into view
  typedef struct packed {
    logic [PIX_W-1:0]      x0;
    logic [PIX_W:0]        y0;
    logic [GLYPH_BITS-1:0] mask;
    logic [COLOR_W-1:0]    color;
  } entry_t;

  // row 0 in the top byte, row 6 in the bottom byte
  localparam logic [55:0] GLYPH_ROM [GLYPH_COUNT] = '{
    56'h00_00_00_00_00_00_00, 56'h00_00_5F_00_00_00_00,
    56'h00_07_00_07_00_00_00, 56'h00_14_7F_14_7F_14_00,
    56'h00_24_2A_7F_2A_12_00, 56'h00_23_13_08_64_62_00,
    56'h00_36_49_55_22_50_00, 56'h00_05_03_00_05_03_00,
    56'h00_1C_22_41_41_82_00, 56'h00_41_22_1C_41_22_00,
    56'h00_14_08_3E_08_14_00, 56'h00_08_08_3E_08_08_00,
    56'h00_80_60_00_20_10_00, 56'h00_08_08_08_08_08_00,
    56'h00_60_60_00_00_00_00, 56'h00_20_10_08_04_02_00,
    56'h00_3E_51_49_45_3E_00, 56'h00_00_42_7F_40_00_00,
    56'h00_42_61_51_49_46_00, 56'h00_21_41_45_4B_31_00,
    56'h00_18_14_12_7F_10_00, 56'h00_27_45_45_45_39_00,
    56'h00_3C_4A_49_49_30_00, 56'h00_01_71_09_05_03_00,
    56'h00_36_49_49_49_36_00, 56'h00_06_49_49_29_1E_00,
    56'h00_00_36_36_00_00_00, 56'h00_00_56_36_00_00_00,
    56'h00_08_14_22_41_00_00, 56'h00_14_14_14_14_14_00,
    56'h00_00_41_22_14_08_00, 56'h00_02_01_51_09_06_00,
    56'h00_32_49_79_41_3E_00, 56'h00_7E_11_11_11_7E_00,
    56'h00_7F_49_49_49_36_00, 56'h00_3E_41_41_41_22_00,
    56'h00_7F_41_41_22_1C_00, 56'h00_7F_49_49_49_41_00,
    56'h00_7F_09_09_09_01_00, 56'h00_3E_41_49_49_7A_00,
    56'h00_7F_08_08_08_7F_00, 56'h00_00_41_7F_41_00_00,
    56'h00_20_40_41_3F_01_00, 56'h00_7F_08_14_22_41_00,
    56'h00_7F_40_40_40_40_00, 56'h00_7F_02_0C_02_7F_00,
    56'h00_7F_04_08_10_7F_00, 56'h00_7F_02_02_02_7F_00,
    56'h00_7F_09_09_09_06_00, 56'h00_7F_02_04_08_7F_00,
    56'h00_7F_09_19_29_46_00, 56'h00_46_49_49_49_31_00,
    56'h00_01_01_7F_01_01_00, 56'h00_3F_40_40_40_3F_00,
    56'h00_1F_20_40_20_1F_00, 56'h00_3F_40_38_40_3F_00,
    56'h00_63_14_08_14_63_00, 56'h00_03_04_78_04_03_00,
    56'h00_61_51_49_45_43_00, 56'h00_00_7F_41_41_00_00,
    56'h00_02_04_08_10_20_00, 56'h00_00_41_41_7F_00_00,
    56'h00_04_02_01_02_04_00, 56'h00_40_40_40_40_40_00,
    56'h00_00_01_02_04_00_00, 56'h00_20_54_54_54_78_00,
    56'h00_7F_48_44_44_38_00, 56'h00_38_44_44_44_20_00,
    56'h00_38_44_44_48_7F_00, 56'h00_38_54_54_54_18_00,
    56'h00_08_7E_09_01_02_00, 56'h00_18_54_54_54_7C_00,
    56'h00_7F_08_04_04_78_00, 56'h00_00_44_7D_40_00_00,
    56'h00_20_40_44_3D_00_00, 56'h00_7F_10_28_44_00_00,
    56'h00_00_41_7F_40_00_00, 56'h00_7C_04_18_04_7C_00,
    56'h00_7C_08_04_04_78_00, 56'h00_38_44_44_44_38_00,
    56'h00_7C_14_14_14_08_00, 56'h00_08_14_14_18_7C_00,
    56'h00_7C_08_04_04_08_00, 56'h00_48_54_54_54_20_00,
    56'h00_04_3F_44_40_20_00, 56'h00_3C_40_40_20_7C_00,
    56'h00_1C_20_40_20_1C_00, 56'h00_3C_40_30_40_3C_00,
    56'h00_44_28_10_28_44_00, 56'h00_0C_50_50_50_3C_00,
    56'h00_44_64_54_4C_44_00, 56'h00_08_36_41_36_08_00,
    56'h00_00_7F_7F_00_00_00, 56'h00_08_41_36_08_08_00,
    56'h00_08_04_08_04_08_00
  };

endpackage

// ===== hw/rtl/bgpe_front.sv =====
// ----------------------------------------------------------------------------
// bgpe_front
// Takes characters, tracks the pen, fetches the glyph and clips it to a mask.
// ----------------------------------------------------------------------------
module bgpe_front
  import bgpe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          in_valid,
  input  logic [7:0]    char_code,
  input  logic          start_text,
  input  logic [15:0]   origin_x,
  input  logic [15:0]   origin_y,
  input  logic [31:0]   ink_color,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output entry_t        push_entry
);

  localparam int PEN_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
  localparam int PX_W  = PEN_W + 1;
  localparam logic signed [PX_W-1:0] PEN_MAX = PX_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);

  logic signed [PEN_W-1:0] pen_x_r, pen_x_nxt;
  logic signed [15:0]      pen_y_r, pen_y_nxt;
  logic signed [PEN_W-1:0] pen_x_eff;
  logic signed [15:0]      pen_y_eff;
  logic signed [PX_W-1:0]  pen_sum;
  logic signed [PX_W-1:0]  px;
  logic signed [16:0]      py;
  logic signed [PX_W-1:0]  wlim;
  logic signed [16:0]      hlim;
  logic [CFG_W-1:0]        wclip, hclip;
  logic                    printable;
  logic [6:0]              glyph_idx;
  logic [55:0]             glyph;
  logic [GLYPH_COLS-1:0]   col_ok;
  logic [GLYPH_ROWS-1:0]   row_ok;
  logic [GLYPH_BITS-1:0]   mask;
  logic                    accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign pen_x_eff = start_text ? PEN_W'($signed(origin_x)) : pen_x_r;
  assign pen_y_eff = start_text ? $signed(origin_y) : pen_y_r;

  assign wclip = (cfg.fb_width  > CLIP_MAX) ? CLIP_MAX : cfg.fb_width;
  assign hclip = (cfg.fb_height > CLIP_MAX) ? CLIP_MAX : cfg.fb_height;
  assign wlim  = $signed(PX_W'(wclip));
  assign hlim  = $signed(17'(hclip));

  assign printable = (char_code >= GLYPH_FIRST) && (char_code <= GLYPH_LAST);
  assign glyph_idx = printable ? 7'(char_code - GLYPH_FIRST) : 7'd0;
  assign glyph     = GLYPH_ROM[glyph_idx];

  always_comb begin
    px = '0;
    py = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      px        = PX_W'(pen_x_eff) + PX_W'(c);
      col_ok[c] = !px[PX_W-1] && (px < wlim);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      py        = 17'(pen_y_eff) + 17'(r);
      row_ok[r] = !py[16] && (py < hlim);
    end
  end

  // bit r*5+c of the mask is column c of row r, bit 0 leftmost
  always_comb begin
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        mask[r*GLYPH_COLS+c] = glyph[55-8*r-(7-c)] && col_ok[c] && row_ok[r]
                               && cfg.enable && printable;
      end
    end
  end

  assign push             = accept && (|mask);
  assign push_entry.x0    = pen_x_eff[PIX_W-1:0];
  assign push_entry.y0    = pen_y_eff[PIX_W:0];
  assign push_entry.mask  = mask;
  assign push_entry.color = ink_color;

  // saturating advance of the pen
  assign pen_sum = PX_W'(pen_x_eff) + PX_W'(GLYPH_ADVANCE);

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (accept) begin
      pen_y_nxt = pen_y_eff;
      pen_x_nxt = (pen_sum > PEN_MAX) ? PEN_W'(PEN_MAX) : PEN_W'(pen_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

// ===== hw/rtl/bgpe_queue.sv =====
// ----------------------------------------------------------------------------
// bgpe_queue
// Short queue of clipped glyphs between the front and the pixel sequencer.
// ----------------------------------------------------------------------------
module bgpe_queue
  import bgpe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/bgpe_back.sv =====
// ----------------------------------------------------------------------------
// bgpe_back
// Walks a glyph mask a bit a cycle unless stalled; a pixel write per set bit.
// ----------------------------------------------------------------------------
module bgpe_back
  import bgpe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                q_empty,
  input  entry_t              head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_W-1:0]    pixel_x,
  output logic [PIX_W-1:0]    pixel_y,
  output logic [ADDR_W-1:0]   word_address,
  output logic [COLOR_W-1:0]  pixel_color,
  output logic                last_pixel
);

  logic                  busy_r;
  logic [GLYPH_BITS-1:0] mask_r;
  logic [2:0]            col_r, row_r;
  logic [PIX_W-1:0]      x0_r;
  logic [PIX_W:0]        y0_r;
  logic [COLOR_W-1:0]    color_r;
  logic [ADDR_W-1:0]     row_addr_r;
  logic [ADDR_W-1:0]     head_row_prod;

  logic                  out_valid_r;
  logic [PIX_W-1:0]      pixel_x_r, pixel_y_r;
  logic [ADDR_W-1:0]     word_address_r;
  logic [COLOR_W-1:0]    pixel_color_r;
  logic                  last_pixel_r;

  logic                  out_free, step, finish, emit;
  logic [PIX_W-1:0]      cur_x, cur_y;

  assign out_free = !out_valid_r || out_ready;
  // a clear bit needs no output slot
  assign step     = busy_r && (!mask_r[0] || out_free);
  assign finish   = step && (mask_r[GLYPH_BITS-1:1] == '0);
  assign emit     = step && mask_r[0];
  assign pop      = (!busy_r || finish) && !q_empty;

  // signed start row, so rows stepped in from above the top edge land right
  assign head_row_prod = ADDR_W'($signed(head.y0)) * ADDR_W'(cfg.row_pitch);
  assign cur_x         = x0_r + PIX_W'(col_r);
  assign cur_y         = y0_r[PIX_W-1:0] + PIX_W'(row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
    end else if (finish) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mask_r     <= head.mask;
      col_r      <= '0;
      row_r      <= '0;
      x0_r       <= head.x0;
      y0_r       <= head.y0;
      color_r    <= head.color;
      row_addr_r <= head_row_prod;
    end else if (step) begin
      mask_r <= mask_r >> 1;
      if (col_r == 3'(GLYPH_COLS - 1)) begin
        col_r      <= '0;
        row_r      <= row_r + 1'b1;
        row_addr_r <= row_addr_r + ADDR_W'(cfg.row_pitch);
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x_r      <= cur_x;
      pixel_y_r      <= cur_y;
      word_address_r <= row_addr_r + ADDR_W'(cur_x);
      pixel_color_r  <= color_r;
      last_pixel_r   <= (mask_r[GLYPH_BITS-1:1] == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign pixel_x      = pixel_x_r;
  assign pixel_y      = pixel_y_r;
  assign word_address = word_address_r;
  assign pixel_color  = pixel_color_r;
  assign last_pixel   = last_pixel_r;

endmodule

// ===== hw/rtl/bitmap_glyph_pixel_emitter.sv =====
// ----------------------------------------------------------------------------
// bitmap_glyph_pixel_emitter
// Renders 5x7 font characters into a stream of framebuffer pixel writes.
//
// The in_ stream carries one character per beat; tuser set loads the pen from
// the origin fields first. The out_ stream carries one pixel write per beat,
// tlast on the final write of a character. The cfg_ APB port holds enable,
// clipping width and height, and the row pitch; write them only while idle.
// A character is taken every cycle while the glyph queue has room; the pen
// advances by 6, saturating, whatever is drawn. The pixel sequencer walks the
// 35-bit glyph mask one bit per cycle, holding on a set bit while the output
// is stalled, and stops after the last set bit; it sets the sustained rate.
// The first write of a character passes through the queue, the sequencer
// registers and the output register, once the sequencer has stepped past every
// clear bit before it. A character that draws nothing takes no sequencer time.
// Reset clears the pen, the queue and the output register and loads the
// register defaults. A stalled receiver holds the current write; the
// sequencer, then the queue, then in_tready back up behind it.
// ----------------------------------------------------------------------------
module bitmap_glyph_pixel_emitter
  import bgpe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: char_code[7:0], origin_x[23:8], origin_y[39:24], ink_color[71:40]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  // in_tuser: start_text[0]
  input  logic        in_tuser,
  // out_tdata: pixel_x[12:0], pixel_y[25:13], word_address[51:26],
  //            pixel_color[83:52], zero fill [87:84]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             enable_r;
  logic [CFG_W-1:0] fb_width_r, fb_height_r, row_pitch_r;
  cfg_t             cfg;
  logic             cfg_write;

  logic             q_full, q_empty, push, pop;
  entry_t           push_entry, head;

  logic [PIX_W-1:0]   pixel_x, pixel_y;
  logic [ADDR_W-1:0]  word_address;
  logic [COLOR_W-1:0] pixel_color;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      fb_width_r  <= 14'd1280;
      fb_height_r <= 14'd720;
      row_pitch_r <= 14'd1280;
    end else if (cfg_write) begin
      unique case (cfg_paddr[3:2])
        REG_ENABLE:    enable_r    <= cfg_pwdata[0];
        REG_FB_WIDTH:  fb_width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_FB_HEIGHT: fb_height_r <= cfg_pwdata[CFG_W-1:0];
        REG_PITCH:     row_pitch_r <= cfg_pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ENABLE:    cfg_prdata = 32'(enable_r);
      REG_FB_WIDTH:  cfg_prdata = 32'(fb_width_r);
      REG_FB_HEIGHT: cfg_prdata = 32'(fb_height_r);
      REG_PITCH:     cfg_prdata = 32'(row_pitch_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.enable    = enable_r;
  assign cfg.fb_width  = fb_width_r;
  assign cfg.fb_height = fb_height_r;
  assign cfg.row_pitch = row_pitch_r;

  bgpe_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .char_code  (in_tdata[7:0]),
    .start_text (in_tuser),
    .origin_x   (in_tdata[23:8]),
    .origin_y   (in_tdata[39:24]),
    .ink_color  (in_tdata[71:40]),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  bgpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  bgpe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .word_address (word_address),
    .pixel_color  (pixel_color),
    .last_pixel   (out_tlast)
  );

  assign out_tdata = {4'b0, pixel_color, word_address, pixel_y, pixel_x};

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 5x7 glyph pixel emitter.
//
// Characters go in on the in_ stream in bursts with random gaps. The out_
// stream stalls on a pattern of its own. Each accepted character is rasterised
// against the package font table, clipped and addressed as the block should.
// Every pixel write that leaves the block must match the oldest pending
// prediction field by field. Register layouts change only while the block is
// idle. The run covers disabled drawing, clipping on every edge, oversize
// and zero framebuffer sizes, address wrap and pen saturation.
// ----------------------------------------------------------------------------
module tb;
  import bgpe_pkg::*;

  localparam int PEN_MAX      = (1 << (COORD_WIDTH_DEF - 1)) - 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_PHASES = 5;
  localparam int CHARS_PER_PHASE = 20;

  typedef struct packed {
    logic        start_text;
    logic [31:0] ink_color;
    logic [15:0] origin_y;
    logic [15:0] origin_x;
    logic [7:0]  char_code;
  } char_beat_t;

  typedef struct packed {
    logic        last;
    logic [31:0] color;
    logic [25:0] addr;
    logic [12:0] y;
    logic [12:0] x;
  } pixel_write_t;

  class glyph_raster_model;
    logic               enable;
    logic [CFG_W-1:0]   fb_width;
    logic [CFG_W-1:0]   fb_height;
    logic [CFG_W-1:0]   pitch;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    pixel_write_t       pending_writes[$];
    int                 mismatches;
    int                 writes_checked;

    function new();
      enable         = 1'b0;
      fb_width       = 14'd1280;
      fb_height      = 14'd720;
      pitch          = 14'd1280;
      pen_x          = '0;
      pen_y          = '0;
      mismatches     = 0;
      writes_checked = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
        REG_ENABLE:    enable    = val[0];
        REG_FB_WIDTH:  fb_width  = val[CFG_W-1:0];
        REG_FB_HEIGHT: fb_height = val[CFG_W-1:0];
        REG_PITCH:     pitch     = val[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_char(input char_beat_t b);
      int           wlim;
      int           hlim;
      int           px;
      int           py;
      int           next_x;
      longint       full_addr;
      logic [55:0]  glyph;
      logic [7:0]   row_bits;
      pixel_write_t w;
      pixel_write_t held;
      bit           have_held;
      have_held = 1'b0;
      held      = '0;
      if (b.start_text) begin
        pen_x = b.origin_x;
        pen_y = b.origin_y;
      end
      if (enable && b.char_code >= GLYPH_FIRST && b.char_code <= GLYPH_LAST) begin
        wlim  = (fb_width > CLIP_MAX) ? int'(CLIP_MAX) : int'(fb_width);
        hlim  = (fb_height > CLIP_MAX) ? int'(CLIP_MAX) : int'(fb_height);
        glyph = GLYPH_ROM[int'(b.char_code) - int'(GLYPH_FIRST)];
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          // row 0 sits in the top byte; only the low five columns count
          row_bits = glyph[55 - 8 * r -: 8];
          for (int c = 0; c < GLYPH_COLS; c++) begin
            px = int'(pen_x) + c;
            py = int'(pen_y) + r;
            if (row_bits[c] && px >= 0 && px < wlim && py >= 0 && py < hlim) begin
              full_addr = longint'(py) * longint'(pitch) + longint'(px);
              w.x     = px[12:0];
              w.y     = py[12:0];
              w.addr  = full_addr[25:0];
              w.color = b.ink_color;
              w.last  = 1'b0;
              if (have_held) pending_writes.push_back(held);
              held      = w;
              have_held = 1'b1;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          pending_writes.push_back(held);
        end
      end
      next_x = int'(pen_x) + GLYPH_ADVANCE;
      pen_x  = (next_x > PEN_MAX) ? 16'(PEN_MAX) : 16'(next_x);
    endfunction

    function void compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_pixel(input pixel_write_t got);
      pixel_write_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel write: expected none, actual x=%0d y=%0d addr=0x%0h",
                 $time, got.x, got.y, got.addr);
        return;
      end
      want = pending_writes.pop_front();
      writes_checked++;
      compare_field("pixel_x", want.x, got.x);
      compare_field("pixel_y", want.y, got.y);
      compare_field("word_address", want.addr, got.addr);
      compare_field("pixel_color", want.color, got.color);
      compare_field("last_pixel", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  glyph_raster_model model;
  int chars_taken  = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;
  int stall_mode   = 0;
  int stall_left   = 0;
  int burst_left   = 0;

  bitmap_glyph_pixel_emitter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: switch between free flow, light and heavy back-pressure
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // monitor and watchdog
  always @(posedge clk) begin
    bit moved;
    pixel_write_t got;
    char_beat_t   seen;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        got.x     = out_tdata[12:0];
        got.y     = out_tdata[25:13];
        got.addr  = out_tdata[51:26];
        got.color = out_tdata[83:52];
        got.last  = out_tlast;
        model.check_pixel(got);
        moved = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        seen.char_code  = in_tdata[7:0];
        seen.origin_x   = in_tdata[23:8];
        seen.origin_y   = in_tdata[39:24];
        seen.ink_color  = in_tdata[71:40];
        seen.start_text = in_tuser;
        model.take_char(seen);
        chars_taken++;
        moved = 1'b1;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d writes still pending",
                 $time, quiet_cycles, model.pending_writes.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic char_beat_t mk(input logic [7:0] code, input logic start, input int ox,
                                    input int oy, input logic [31:0] ink);
    char_beat_t b;
    b.char_code  = code;
    b.start_text = start;
    b.origin_x   = ox[15:0];
    b.origin_y   = oy[15:0];
    b.ink_color  = ink;
    return b;
  endfunction

  function automatic char_beat_t random_char(input bit first, input int w, input int h);
    char_beat_t b;
    b.ink_color = $urandom;
    b.char_code = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(32, 126));
    b.origin_x  = 16'($urandom);
    b.origin_y  = 16'($urandom);
    b.start_text = first ? 1'b1 : ($urandom_range(0, 19) == 0);
    // keep most runs near the visible area so that pixels survive clipping
    if (first && $urandom_range(0, 4) != 0) begin
      b.origin_x = 16'($urandom_range(0, w + 8) - 6);
      b.origin_y = 16'($urandom_range(0, h + 10) - 8);
    end
    return b;
  endfunction

  task automatic send_char(input char_beat_t b);
    in_tvalid <= 1'b1;
    in_tdata  <= {b.ink_color, b.origin_y, b.origin_x, b.char_code};
    in_tuser  <= b.start_text;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    model.set_reg(idx, val);
    reg_writes++;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // bus back to idle before the next transfer
    @(posedge clk);
  endtask

  task automatic apply_layout(input logic en, input int w, input int h, input int p);
    write_reg(REG_FB_WIDTH, 32'(w));
    write_reg(REG_FB_HEIGHT, 32'(h));
    write_reg(REG_PITCH, 32'(p));
    write_reg(REG_ENABLE, 32'(en));
  endtask

  initial begin
    int w;
    int h;
    int run_len;
    int sent;
    char_beat_t b;
    model = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: pen moves, nothing drawn
    send_char(mk("A", 1'b1, 10, 10, 32'h00FF_FFFF));
    send_char(mk("#", 1'b0, 0, 0, 32'h1234_5678));
    wait_idle();

    // enable only, keep the reset framebuffer layout
    write_reg(REG_ENABLE, 32'd1);
    send_char(mk("!", 1'b1, 0, 0, 32'hFFFF_FFFF));
    send_char(mk("~", 1'b0, 0, 0, 32'h0000_0000));
    send_char(mk(" ", 1'b0, 0, 0, 32'h5555_5555));
    send_char(mk(8'd31, 1'b0, 0, 0, 32'hAAAA_AAAA));
    send_char(mk(8'd127, 1'b0, 0, 0, 32'hAAAA_AAAA));
    send_char(mk(8'd255, 1'b0, 0, 0, 32'hAAAA_AAAA));
    send_char(mk(8'd0, 1'b0, 0, 0, 32'hAAAA_AAAA));
    send_char(mk("H", 1'b0, -1, -1, 32'h0F0F_0F0F));
    send_char(mk("W", 1'b1, -2, -3, 32'hF0F0_F0F0));
    send_char(mk("@", 1'b1, 1277, 717, 32'h8000_0001));
    send_char(mk("8", 1'b1, 32765, 5, 32'h0000_00FF));
    send_char(mk("8", 1'b0, 0, 0, 32'h0000_FF00));
    send_char(mk("M", 1'b1, -32768, -32768, 32'h00FF_0000));
    // glyphs whose table rows carry bits above the five columns
    send_char(mk("(", 1'b1, 50, 50, 32'hDEAD_BEEF));
    send_char(mk(",", 1'b0, 0, 0, 32'hCAFE_F00D));
    wait_idle();

    // oversize layout: clip at 8192 and wrap the word address
    apply_layout(1'b1, 16383, 16383, 16383);
    send_char(mk("M", 1'b1, 8185, 8185, 32'hA5A5_5A5A));
    send_char(mk("#", 1'b0, 0, 0, 32'h5A5A_A5A5));
    wait_idle();
    apply_layout(1'b1, 0, 0, 0);
    send_char(mk("B", 1'b1, 0, 0, 32'h1111_1111));
    wait_idle();
    apply_layout(1'b1, 8192, 8192, 0);
    send_char(mk("N", 1'b1, 8188, 0, 32'h2222_2222));

    burst_left = $urandom_range(1, 16);
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase == 0) begin
        w = 1280;
        h = 720;
        apply_layout(1'b1, w, h, w);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(8, 640);
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(8, 480);
        apply_layout($urandom_range(0, 5) != 0, w, h,
                     ($urandom_range(0, 1) == 0) ? w : $urandom_range(0, 16383));
      end
      sent = 0;
      while (sent < CHARS_PER_PHASE) begin
        run_len = $urandom_range(1, 8);
        for (int k = 0; k < run_len; k++) begin
          b = random_char(k == 0, w, h);
          send_char(b);
          sent++;
          burst_left--;
          if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
          end
        end
        // hold off now and then until the block has emptied
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end

    wait_idle();
    $display("Ran %0d characters through %0d register writes, checked %0d pixel writes,",
             chars_taken, reg_writes, model.writes_checked);
    $display("covering disabled drawing, edge clipping, oversize layouts and pen saturation.");
    if (model.mismatches == 0 && model.pending_writes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== bitmap_glyph_pixel_emitter.f =====
hw/rtl/bgpe_pkg.sv
hw/rtl/bgpe_front.sv
hw/rtl/bgpe_queue.sv
hw/rtl/bgpe_back.sv
hw/rtl/bitmap_glyph_pixel_emitter.sv
bench/tb.sv
